// ----- hdl/afr_pkg.sv -----
// Shared types, constants and frame-type helpers for the API frame receiver.
// No dependencies.
package afr_pkg;

	localparam logic [6:0] MAX_FRAME_LEN = 7'd100;
	localparam logic [7:0] START_BYTE    = 8'h7E;
	localparam logic [7:0] CHECK_INIT    = 8'hFF;

	localparam logic [2:0] CFG_MODEM_CODE  = 3'd0;
	localparam logic [2:0] CFG_AT_CODE     = 3'd1;
	localparam logic [2:0] CFG_REMOTE_CODE = 3'd2;
	localparam logic [2:0] CFG_TX_CODE     = 3'd3;
	localparam logic [2:0] CFG_RX_CODE     = 3'd4;
	localparam logic [2:0] CFG_EXPL_CODE   = 3'd5;
	localparam logic [2:0] CFG_NODE_CODE   = 3'd6;
	localparam logic [2:0] CFG_IDLE_LIMIT  = 3'd7;

	localparam logic [1:0] RES_PAYLOAD   = 2'd0;
	localparam logic [1:0] RES_GOOD      = 2'd1;
	localparam logic [1:0] RES_BAD       = 2'd2;

	typedef enum logic [2:0] {
		K_NONE   = 3'd0,
		K_MODEM  = 3'd1,
		K_AT     = 3'd2,
		K_REMOTE = 3'd3,
		K_TX     = 3'd4,
		K_RX     = 3'd5,
		K_EXPL   = 3'd6,
		K_NODE   = 3'd7
	} kind_t;

	typedef enum logic [5:0] {
		PH_HUNT   = 6'b000001,
		PH_LEN_HI = 6'b000010,
		PH_LEN_LO = 6'b000100,
		PH_TYPE   = 6'b001000,
		PH_BODY   = 6'b010000,
		PH_CHECK  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0]  modem_code;
		logic [7:0]  at_code;
		logic [7:0]  remote_code;
		logic [7:0]  tx_code;
		logic [7:0]  rx_code;
		logic [7:0]  expl_code;
		logic [7:0]  node_code;
		logic [15:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] byte_value;
		kind_t      kind;
		logic       is_start;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	function automatic kind_t kind_of(input cfg_t cfg, input logic [7:0] t);
		kind_t k;
		if (t == cfg.modem_code)       k = K_MODEM;
		else if (t == cfg.at_code)     k = K_AT;
		else if (t == cfg.remote_code) k = K_REMOTE;
		else if (t == cfg.tx_code)     k = K_TX;
		else if (t == cfg.rx_code)     k = K_RX;
		else if (t == cfg.expl_code)   k = K_EXPL;
		else if (t == cfg.node_code)   k = K_NODE;
		else                           k = K_NONE;
		return k;
	endfunction

	function automatic logic [6:0] payload_start(input kind_t k);
		logic [6:0] off;
		unique case (k)
			K_AT:     off = 7'd4;
			K_REMOTE: off = 7'd14;
			K_RX:     off = 7'd11;
			K_EXPL:   off = 7'd17;
			default:  off = 7'd0;
		endcase
		return off;
	endfunction

endpackage

// ----- hdl/afr_in_if.sv -----
// Input channel: received byte or millisecond tick, valid/ready handshake.
// Depends on nothing.
interface afr_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_value;

	modport source(output valid, mode, byte_value, input ready);
	modport sink(input valid, mode, byte_value, output ready);
endinterface

// ----- hdl/afr_out_if.sv -----
// Result channel: payload bytes and frame results, valid/ready handshake.
// Depends on nothing.
interface afr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  frame_type;
	logic [7:0]  payload_byte;
	logic [6:0]  payload_index;
	logic [7:0]  frame_tag;
	logic [63:0] source_address;
	logic [15:0] network_address;
	logic [7:0]  delivery_status;
	logic [7:0]  modem_state;
	logic [15:0] at_name;

	modport source(output valid, result_kind, frame_type, payload_byte, payload_index,
		frame_tag, source_address, network_address, delivery_status, modem_state,
		at_name, input ready);
	modport sink(input valid, result_kind, frame_type, payload_byte, payload_index,
		frame_tag, source_address, network_address, delivery_status, modem_state,
		at_name, output ready);
endinterface

// ----- hdl/afr_front.sv -----
// Front end: accepts input transactions, classifies the byte against the
// type codes and holds them in a two-entry queue. Uses afr_pkg, afr_in_if.
module afr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  afr_pkg::cfg_t     cfg,
	afr_in_if.sink            in_ch,
	output afr_pkg::q_head_t  head,
	input  logic              pop
);
	import afr_pkg::*;

	item_t      q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      new_item;

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		new_item.mode       = in_ch.mode;
		new_item.byte_value = in_ch.byte_value;
		new_item.kind       = kind_of(cfg, in_ch.byte_value);
		new_item.is_start   = (in_ch.byte_value == START_BYTE);
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty queue");
`endif

endmodule

// ----- hdl/afr_back.sv -----
// Back end: frame parser, held field registers and result output register.
// Uses afr_pkg, afr_out_if; fed from the afr_front queue.
module afr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  afr_pkg::cfg_t     cfg,
	input  afr_pkg::q_head_t  head,
	output logic              pop,
	afr_out_if.source         out_ch
);
	import afr_pkg::*;

	phase_t      phase_q, phase_d, ph;
	logic [6:0]  frame_length_q, frame_length_d;
	logic [7:0]  current_type_q, current_type_d;
	logic [6:0]  body_index_q, body_index_d, bi, bi_inc, off, j;
	logic [7:0]  check_q, check_d, chk;
	logic [15:0] idle_q, idle_d;
	logic [63:0] source_q, source_d;
	logic [15:0] network_q, network_d;
	logic [7:0]  tag_q, tag_d;
	logic [7:0]  delivery_q, delivery_d;
	logic [7:0]  modem_q, modem_d;
	logic [15:0] at_name_q, at_name_d;
	kind_t       kc;
	logic        addr;
	logic        res_fire;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [6:0]  res_index;
	logic [7:0]  b;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  type_out_q;
	logic [7:0]  pbyte_q;
	logic [6:0]  pindex_q;
	logic [7:0]  tag_out_q;
	logic [63:0] source_out_q;
	logic [15:0] network_out_q;
	logic [7:0]  delivery_out_q;
	logic [7:0]  modem_out_q;
	logic [15:0] at_name_out_q;

	assign pop = head.valid && (!out_valid_q || out_ch.ready);
	assign b   = head.item.byte_value;
	assign kc  = kind_of(cfg, current_type_q);
	assign off = payload_start(kc);

	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		current_type_d = current_type_q;
		body_index_d   = body_index_q;
		check_d        = check_q;
		idle_d         = idle_q;
		source_d       = source_q;
		network_d      = network_q;
		tag_d          = tag_q;
		delivery_d     = delivery_q;
		modem_d        = modem_q;
		at_name_d      = at_name_q;
		res_fire       = 1'b0;
		res_kind       = RES_PAYLOAD;
		res_byte       = 8'd0;
		res_index      = 7'd0;
		ph             = phase_q;
		bi             = body_index_q;
		chk            = check_q;
		bi_inc         = body_index_q;
		addr           = 1'b0;
		j              = body_index_q;
		if (pop) begin
			if (head.item.mode) begin
				if (idle_q != 16'd0) idle_d = idle_q - 16'd1;
			end else begin
				if (idle_q == 16'd0) begin
					ph  = PH_HUNT;
					bi  = 7'd0;
					chk = CHECK_INIT;
				end
				idle_d       = cfg.idle_limit;
				phase_d      = ph;
				body_index_d = bi;
				check_d      = chk;
				bi_inc       = (bi == 7'd127) ? bi : bi + 7'd1;
				unique case (ph)
					PH_LEN_HI: phase_d = PH_LEN_LO;
					PH_LEN_LO: begin
						frame_length_d = (b > {1'b0, MAX_FRAME_LEN}) ? MAX_FRAME_LEN
							: b[6:0];
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						current_type_d = b;
						check_d        = chk - b;
						if (head.item.kind == K_NONE) phase_d = PH_HUNT;
						else if (frame_length_q <= 7'd1) phase_d = PH_CHECK;
						else phase_d = PH_BODY;
					end
					PH_BODY: begin
						if (kc == K_NONE) begin
							phase_d = PH_HUNT;
						end else begin
							unique case (kc)
								K_MODEM: if (bi == 7'd0) modem_d = b;
								K_AT: begin
									if (bi == 7'd0) tag_d = b;
									else if (bi == 7'd1) at_name_d = {8'd0, b};
									else if (bi == 7'd2) at_name_d = {at_name_q[7:0], b};
								end
								K_TX: begin
									if (bi == 7'd0) tag_d = b;
									else if (bi == 7'd1) network_d = {8'd0, b};
									else if (bi == 7'd2) network_d = {network_q[7:0], b};
									else if (bi == 7'd4) delivery_d = b;
								end
								K_REMOTE: begin
									addr = (bi >= 7'd1);
									j    = bi - 7'd1;
									if (bi == 7'd0) tag_d = b;
									else if (bi == 7'd11) at_name_d = {8'd0, b};
									else if (bi == 7'd12) at_name_d = {at_name_q[7:0], b};
								end
								default: addr = 1'b1;
							endcase
							if (addr) begin
								if (j <= 7'd7) source_d = {source_q[55:0], b};
								else if (j == 7'd8) network_d = {8'd0, b};
								else if (j == 7'd9) network_d = {network_q[7:0], b};
							end
							if (off != 7'd0 && bi >= off) begin
								res_fire  = 1'b1;
								res_kind  = RES_PAYLOAD;
								res_byte  = b;
								res_index = bi - off;
							end
							check_d      = chk - b;
							body_index_d = bi_inc;
							if (frame_length_q <= 7'd1
								|| ({1'b0, bi_inc} + 8'd1) >= {1'b0, frame_length_q})
								phase_d = PH_CHECK;
						end
					end
					PH_CHECK: begin
						res_fire  = 1'b1;
						res_kind  = (chk == b) ? RES_GOOD : RES_BAD;
						res_index = (off != 7'd0 && bi > off) ? bi - off : 7'd0;
						phase_d   = PH_HUNT;
					end
					default: begin
						phase_d = PH_HUNT;
						if (head.item.is_start) begin
							phase_d      = PH_LEN_HI;
							body_index_d = 7'd0;
							check_d      = CHECK_INIT;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			frame_length_q <= 7'd0;
			current_type_q <= 8'd0;
			body_index_q   <= 7'd0;
			check_q        <= CHECK_INIT;
			idle_q         <= 16'd0;
			source_q       <= 64'd0;
			network_q      <= 16'd0;
			tag_q          <= 8'd0;
			delivery_q     <= 8'd0;
			modem_q        <= 8'd0;
			at_name_q      <= 16'd0;
			out_valid_q    <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			current_type_q <= current_type_d;
			body_index_q   <= body_index_d;
			check_q        <= check_d;
			idle_q         <= idle_d;
			source_q       <= source_d;
			network_q      <= network_d;
			tag_q          <= tag_d;
			delivery_q     <= delivery_d;
			modem_q        <= modem_d;
			at_name_q      <= at_name_d;
			if (pop && res_fire) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_fire) begin
			kind_q         <= res_kind;
			type_out_q     <= current_type_q;
			pbyte_q        <= res_byte;
			pindex_q       <= res_index;
			tag_out_q      <= tag_d;
			source_out_q   <= source_d;
			network_out_q  <= network_d;
			delivery_out_q <= delivery_d;
			modem_out_q    <= modem_d;
			at_name_out_q  <= at_name_d;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.result_kind     = kind_q;
	assign out_ch.frame_type      = type_out_q;
	assign out_ch.payload_byte    = pbyte_q;
	assign out_ch.payload_index   = pindex_q;
	assign out_ch.frame_tag       = tag_out_q;
	assign out_ch.source_address  = source_out_q;
	assign out_ch.network_address = network_out_q;
	assign out_ch.delivery_status = delivery_out_q;
	assign out_ch.modem_state     = modem_out_q;
	assign out_ch.at_name         = at_name_out_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !pop) else $error("result overwritten");
	a_idle_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head.item.mode) |=> idle_q == $past(cfg.idle_limit))
		else $error("idle counter not reloaded");
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> frame_length_q >= 7'd2)
		else $error("body phase with short frame");
	a_check_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head.item.mode && idle_q != 16'd0 && phase_q == PH_CHECK)
		|=> out_valid_q && out_ch.result_kind != RES_PAYLOAD)
		else $error("checksum byte gave no frame result");
`endif

endmodule

// ----- hdl/api_frame_receiver_core.sv -----
// API frame receiver top level: configuration registers, front queue and parser.
// Uses afr_pkg, afr_in_if, afr_out_if, afr_front, afr_back.
// Input bytes pass through the front queue; results are held in the result output register.
// Throughput: one input transaction per cycle while the queue has room; the two-entry
// queue and the result register let input and output stall independently.
// Reset (arst_n low) clears the parser, held fields and queue and loads default codes.
module api_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	afr_in_if.sink      in_ch,
	afr_out_if.source   out_ch
);
	import afr_pkg::*;

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modem_code  <= 8'h8A;
			cfg_q.at_code     <= 8'h88;
			cfg_q.remote_code <= 8'h97;
			cfg_q.tx_code     <= 8'h8B;
			cfg_q.rx_code     <= 8'h90;
			cfg_q.expl_code   <= 8'h91;
			cfg_q.node_code   <= 8'h95;
			cfg_q.idle_limit  <= 16'd500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODEM_CODE:  cfg_q.modem_code  <= cfg_wdata[7:0];
				CFG_AT_CODE:     cfg_q.at_code     <= cfg_wdata[7:0];
				CFG_REMOTE_CODE: cfg_q.remote_code <= cfg_wdata[7:0];
				CFG_TX_CODE:     cfg_q.tx_code     <= cfg_wdata[7:0];
				CFG_RX_CODE:     cfg_q.rx_code     <= cfg_wdata[7:0];
				CFG_EXPL_CODE:   cfg_q.expl_code   <= cfg_wdata[7:0];
				CFG_NODE_CODE:   cfg_q.node_code   <= cfg_wdata[7:0];
				CFG_IDLE_LIMIT:  cfg_q.idle_limit  <= cfg_wdata;
				default:         cfg_q.idle_limit  <= cfg_q.idle_limit;
			endcase
		end
	end

	afr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	afr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
